/* design/sbgs_pkg.sv */
package sbgs_pkg;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_MOTION  = 2'd3
  } sbgs_op_t;

  localparam logic [1:0] TAP_NONE   = 2'd0;
  localparam logic [1:0] TAP_LEFT   = 2'd1;
  localparam logic [1:0] TAP_RIGHT  = 2'd2;
  localparam logic [1:0] TAP_MIDDLE = 2'd3;

  localparam logic [1:0] CLICKS_NONE   = 2'd0;
  localparam logic [1:0] CLICKS_SINGLE = 2'd1;
  localparam logic [1:0] CLICKS_DOUBLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_HOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_ARM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_ARM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_MIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_MIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_DIV   = 3'd7;

  localparam logic [6:0] MIN_DIVISOR = 7'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic div_init;
    logic div_step;
    logic emit;
  } sbgs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic out_busy;
  } sbgs_sts_t;

endpackage

/* design/sbgs_div.sv */
module sbgs_div (
  input  logic              clk,
  input  logic              init,
  input  logic              step,
  input  logic signed [8:0] dividend,
  input  logic        [6:0] divisor,
  output logic signed [7:0] quot,
  output logic signed [8:0] rem
);
  import sbgs_pkg::*;

  logic [6:0] dvs;
  logic [6:0] part;
  logic [7:0] q;
  logic       neg;
  logic [7:0] trial;
  logic [7:0] diff;
  logic       fits;
  logic [7:0] mag_in;
  logic [8:0] neg_in;

  assign neg_in = 9'(~dividend + 9'sd1);
  assign mag_in = dividend[8] ? neg_in[7:0] : dividend[7:0];

  // restoring step, one quotient bit per cycle while step is high, magnitude only
  assign trial = {part, q[7]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (init) begin
      part <= '0;
      q    <= mag_in;
      neg  <= dividend[8];
      dvs  <= divisor;
    end else if (step) begin
      part <= fits ? diff[6:0] : trial[6:0];
      q    <= {q[6:0], fits};
    end
  end

  // truncation toward zero: remainder takes the dividend's sign
  assign quot = neg ? 8'(~q + 8'd1) : q;
  assign rem  = neg ? 9'(~{2'b00, part} + 9'd1) : {2'b00, part};

endmodule

/* design/sbgs_ctrl.sv */
module sbgs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sbgs_pkg::sbgs_sts_t sts,
  output sbgs_pkg::sbgs_cmd_t cmd
);
  import sbgs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval     = 1'b1;
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = sts.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = DIV_CNT_W'(cnt + 1'b1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt != DIV_CNT_W'(DIV_STEPS - 1)) |=> state == S_DIV)
    else $error("divider left early");
  a_eval_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EVAL)
    else $error("accepted word not evaluated");
`endif

endmodule

/* design/sbgs_dpath.sv */
module sbgs_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [sbgs_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [sbgs_pkg::CFG_DATA_W-1:0]      wr_data,
  input  logic [1:0]                           s_tuser,
  input  logic [sbgs_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sbgs_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  sbgs_pkg::sbgs_cmd_t                  cmd,
  output sbgs_pkg::sbgs_sts_t                  sts
);
  import sbgs_pkg::*;

  // configuration
  logic [15:0] right_hold_ms, middle_hold_ms, scroll_arm_ms, double_click_ms, drag_arm_ms;
  logic [7:0]  drag_move_min, scroll_move_min;
  logic [6:0]  scroll_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_hold_ms   <= 16'd400;
      middle_hold_ms  <= 16'd250;
      scroll_arm_ms   <= 16'd120;
      double_click_ms <= 16'd250;
      drag_arm_ms     <= 16'd70;
      drag_move_min   <= 8'd2;
      scroll_move_min <= 8'd3;
      scroll_divisor  <= 7'd17;
    end else if (wr_en) begin
      case (wr_index)
        REG_RIGHT_HOLD:   right_hold_ms   <= wr_data;
        REG_MIDDLE_HOLD:  middle_hold_ms  <= wr_data;
        REG_SCROLL_ARM:   scroll_arm_ms   <= wr_data;
        REG_DOUBLE_CLICK: double_click_ms <= wr_data;
        REG_DRAG_ARM:     drag_arm_ms     <= wr_data;
        REG_DRAG_MIN:     drag_move_min   <= wr_data[7:0];
        REG_SCROLL_MIN:   scroll_move_min <= wr_data[7:0];
        REG_SCROLL_DIV:   scroll_divisor  <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  // captured word
  sbgs_op_t          in_op;
  logic [15:0]       in_now;
  logic signed [7:0] in_dx, in_dy, in_wh, in_wv;
  logic [7:0]        in_btn;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_op  <= sbgs_op_t'(s_tuser);
      in_now <= s_tdata[15:0];
      in_dx  <= s_tdata[23:16];
      in_dy  <= s_tdata[31:24];
      in_btn <= s_tdata[39:32];
      in_wh  <= s_tdata[47:40];
      in_wv  <= s_tdata[55:48];
    end
  end

  // gesture state
  logic              button_down, hold_sent, gesture_triggered, drag_active, scroll_active;
  logic [1:0]        click_tally, press_clicks;
  logic [15:0]       press_stamp, release_stamp;
  logic signed [8:0] accum_h, accum_v;

  logic              button_down_next, hold_sent_next, gesture_triggered_next;
  logic              drag_active_next, scroll_active_next;
  logic [1:0]        click_tally_next, press_clicks_next;
  logic [15:0]       press_stamp_next, release_stamp_next;
  logic              accum_clear;

  logic [1:0]        tap;
  logic signed [7:0] ox, oy, oh, ov;
  logic [7:0]        ob;
  logic              need_div;
  logic signed [8:0] sum_h, sum_v;

  logic [15:0] held, since_rel;
  logic [7:0]  ax, ay;
  logic        mv_drag, mv_scroll, enter_scroll;

  assign held      = in_now - press_stamp;
  assign since_rel = in_now - release_stamp;
  assign ax        = in_dx[7] ? 8'(~in_dx + 8'd1) : in_dx;
  assign ay        = in_dy[7] ? 8'(~in_dy + 8'd1) : in_dy;
  assign mv_drag   = (ax >= drag_move_min) || (ay >= drag_move_min);
  assign mv_scroll = (ax >= scroll_move_min) || (ay >= scroll_move_min);

  always_comb begin
    button_down_next       = button_down;
    hold_sent_next         = hold_sent;
    gesture_triggered_next = gesture_triggered;
    drag_active_next       = drag_active;
    scroll_active_next     = scroll_active;
    click_tally_next       = click_tally;
    press_clicks_next      = press_clicks;
    press_stamp_next       = press_stamp;
    release_stamp_next     = release_stamp;
    accum_clear            = 1'b0;
    enter_scroll           = 1'b0;
    tap = TAP_NONE;
    ox  = '0;
    oy  = '0;
    oh  = '0;
    ov  = '0;
    ob  = '0;
    case (in_op)
      OP_TICK: begin
        if (button_down && !scroll_active && !hold_sent && !gesture_triggered) begin
          if (press_clicks == CLICKS_SINGLE && held >= right_hold_ms) begin
            tap               = TAP_RIGHT;
            hold_sent_next    = 1'b1;
            click_tally_next  = CLICKS_NONE;
            press_clicks_next = CLICKS_NONE;
          end else if (press_clicks == CLICKS_DOUBLE && held >= middle_hold_ms) begin
            tap               = TAP_MIDDLE;
            hold_sent_next    = 1'b1;
            click_tally_next  = CLICKS_NONE;
            press_clicks_next = CLICKS_NONE;
          end
        end
      end
      OP_PRESS: begin
        button_down_next       = 1'b1;
        hold_sent_next         = 1'b0;
        gesture_triggered_next = 1'b0;
        drag_active_next       = 1'b0;
        if (since_rel < double_click_ms && click_tally == CLICKS_SINGLE)
          click_tally_next = CLICKS_DOUBLE;
        else
          click_tally_next = CLICKS_SINGLE;
        press_clicks_next = click_tally_next;
        press_stamp_next  = in_now;
      end
      OP_RELEASE: begin
        button_down_next   = 1'b0;
        release_stamp_next = in_now;
        if (scroll_active) begin
          scroll_active_next = 1'b0;
          click_tally_next   = CLICKS_NONE;
          press_clicks_next  = CLICKS_NONE;
          accum_clear        = 1'b1;
        end else if (drag_active) begin
          drag_active_next  = 1'b0;
          click_tally_next  = CLICKS_NONE;
          press_clicks_next = CLICKS_NONE;
        end else if (hold_sent) begin
          press_clicks_next = CLICKS_NONE;
        end else if (press_clicks == CLICKS_DOUBLE) begin
          if (!gesture_triggered) tap = TAP_LEFT;
          click_tally_next  = CLICKS_NONE;
          press_clicks_next = CLICKS_NONE;
        end else begin
          tap = TAP_LEFT;
        end
      end
      OP_MOTION: begin
        if (button_down && !scroll_active && !gesture_triggered) begin
          if (press_clicks == CLICKS_DOUBLE) begin
            if (held >= scroll_arm_ms && mv_scroll) begin
              scroll_active_next     = 1'b1;
              gesture_triggered_next = 1'b1;
              click_tally_next       = CLICKS_NONE;
              press_clicks_next      = CLICKS_NONE;
              enter_scroll           = 1'b1;
            end
          end else if (press_clicks == CLICKS_SINGLE && !hold_sent) begin
            if (held >= drag_arm_ms && mv_drag) begin
              drag_active_next       = 1'b1;
              gesture_triggered_next = 1'b1;
            end
          end
        end
        ob = drag_active_next ? (in_btn | 8'h01) : (in_btn & 8'hFE);
        if (!scroll_active_next) begin
          ox = in_dx;
          oy = in_dy;
          oh = in_wh;
          ov = in_wv;
        end
      end
      default: ;
    endcase
  end

  assign need_div = (in_op == OP_MOTION) && scroll_active_next;
  // vertical axis inverted
  assign sum_h = (enter_scroll ? 9'sd0 : accum_h) + 9'(in_dx);
  assign sum_v = (enter_scroll ? 9'sd0 : accum_v) - 9'(in_dy);

  logic [6:0]        div_eff;
  logic signed [7:0] quot_h, quot_v;
  logic signed [8:0] rem_h, rem_v;

  assign div_eff = (scroll_divisor < MIN_DIVISOR) ? MIN_DIVISOR : scroll_divisor;

  sbgs_div u_div_h (
    .clk      (clk),
    .init     (cmd.div_init),
    .step     (cmd.div_step),
    .dividend (sum_h),
    .divisor  (div_eff),
    .quot     (quot_h),
    .rem      (rem_h)
  );

  sbgs_div u_div_v (
    .clk      (clk),
    .init     (cmd.div_init),
    .step     (cmd.div_step),
    .dividend (sum_v),
    .divisor  (div_eff),
    .quot     (quot_v),
    .rem      (rem_v)
  );

  // result held between evaluation and hand-off
  logic [1:0]        res_tap;
  logic signed [7:0] res_x, res_y, res_h, res_v;
  logic [7:0]        res_b;
  logic              div_pending;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_tap     <= tap;
      res_x       <= ox;
      res_y       <= oy;
      res_h       <= oh;
      res_v       <= ov;
      res_b       <= ob;
      div_pending <= need_div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_down       <= 1'b0;
      hold_sent         <= 1'b0;
      gesture_triggered <= 1'b0;
      drag_active       <= 1'b0;
      scroll_active     <= 1'b0;
      click_tally       <= CLICKS_NONE;
      press_clicks      <= CLICKS_NONE;
      press_stamp       <= '0;
      release_stamp     <= '0;
      accum_h           <= '0;
      accum_v           <= '0;
    end else begin
      if (cmd.eval) begin
        button_down       <= button_down_next;
        hold_sent         <= hold_sent_next;
        gesture_triggered <= gesture_triggered_next;
        drag_active       <= drag_active_next;
        scroll_active     <= scroll_active_next;
        click_tally       <= click_tally_next;
        press_clicks      <= press_clicks_next;
        press_stamp       <= press_stamp_next;
        release_stamp     <= release_stamp_next;
        if (accum_clear) begin
          accum_h <= '0;
          accum_v <= '0;
        end
      end
      // remainder kept for the next motion word
      if (cmd.emit && div_pending) begin
        accum_h <= rem_h;
        accum_v <= rem_v;
      end
    end
  end

  // output register
  logic signed [7:0] fin_h, fin_v;

  assign fin_h = div_pending ? quot_h : res_h;
  assign fin_v = div_pending ? quot_v : res_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {6'b0, res_b, fin_v, fin_h, res_y, res_x, res_tap};
    end
  end

  assign sts.need_div = need_div;
  assign sts.out_busy = m_tvalid && !m_tready;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_tvalid && !m_tready))
    else $error("output word overwritten while stalled");
  a_release_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && in_op == OP_RELEASE) |=> (!scroll_active && !drag_active && !button_down))
    else $error("release left a gesture active");
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(scroll_active && drag_active))
    else $error("scroll and drag active together");
  a_clicks_range: assert property (@(posedge clk) disable iff (rst)
    click_tally != 2'd3 && press_clicks != 2'd3)
    else $error("click count out of range");
`endif

endmodule

/* design/smart_button_gesture_scroll.sv */
// Single-button gesture engine.
//
// Input stream (s_*): one word per event. s_tuser carries the operation
// (tick, press, release, motion); s_tdata carries time stamp, motion,
// buttons and wheel. Output stream (m_*): exactly one word per input word,
// in order: tap code, x, y, horizontal and vertical scroll, buttons.
// Configuration: wr_en / wr_index / wr_data, one register per write,
// taken at any edge with wr_en high; write only while no word is in flight.
//
// Flow: a word is taken only in the idle state. Each word then passes
// through the evaluate state and the finish state, whose emit sets m_tvalid;
// motion in scroll mode also passes through the divide state, since both
// axes go through an 8-step restoring divider (one quotient bit per cycle).
// A word is taken only after the previous result has entered the output register.
// The result sits in an output register, so the next word is accepted and
// evaluated while a finished word waits; a stalled receiver holds back only
// the hand-off of the following result.
// Reset (rst, synchronous): gesture state idle, accumulators zero, all
// configuration registers at their defaults, no output word pending.
module smart_button_gesture_scroll (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [sbgs_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [sbgs_pkg::CFG_DATA_W-1:0]     wr_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [1:0]                          s_tuser,  // operation
  // now_ms[15:0], dx[23:16], dy[31:24], buttons_in[39:32],
  // wheel_h_in[47:40], wheel_v_in[55:48]
  input  logic [sbgs_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tap_button[1:0], out_x[9:2], out_y[17:10], out_h[25:18],
  // out_v[33:26], buttons_out[41:34], zero above
  output logic [sbgs_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import sbgs_pkg::*;

  sbgs_cmd_t cmd;
  sbgs_sts_t sts;

  sbgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbgs_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

/* sim/sbgs_gesture_checker.sv */
`timescale 1ns / 100ps

module sbgs_gesture_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [sbgs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sbgs_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [1:0]                      s_tuser,  // operation
  // now_ms[15:0], dx[23:16], dy[31:24], buttons_in[39:32],
  // wheel_h_in[47:40], wheel_v_in[55:48]
  input  logic [sbgs_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // tap_button[1:0], out_x[9:2], out_y[17:10], out_h[25:18],
  // out_v[33:26], buttons_out[41:34], zero above
  input  logic [sbgs_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                              results_seen,
  output int                              open_count,
  output int                              fail_count
);
  import sbgs_pkg::*;

  // field order matches m_tdata from bit 41 down to bit 0
  typedef struct packed {
    logic [7:0]        buttons;
    logic signed [7:0] v;
    logic signed [7:0] h;
    logic signed [7:0] y;
    logic signed [7:0] x;
    logic [1:0]        tap;
  } report_t;

  report_t report_q[$];
  int      mismatch_n = 0;

  logic [15:0] cfg_right_hold, cfg_middle_hold, cfg_scroll_arm;
  logic [15:0] cfg_double_click, cfg_drag_arm;
  logic [7:0]  cfg_drag_min, cfg_scroll_min;
  logic [6:0]  cfg_divisor;

  logic        btn_down, hold_sent, gesture_done, dragging, scrolling;
  logic [1:0]  click_tally, press_clicks;
  logic [15:0] press_t, release_t;
  int          acc_h, acc_v;

  task automatic predict_report(input logic [1:0] op, input logic [IN_DATA_W-1:0] d,
                                output report_t r);
    logic [15:0]       now, held, gap;
    logic signed [7:0] dx, dy, wh, wv;
    logic [7:0]        btn;
    int                ax, ay, div, qh, qv;
    logic              mv_drag, mv_scroll;
    now  = d[15:0];
    dx   = d[23:16];
    dy   = d[31:24];
    btn  = d[39:32];
    wh   = d[47:40];
    wv   = d[55:48];
    r    = '0;
    held = now - press_t;
    gap  = now - release_t;
    case (op)
      OP_TICK: begin
        if (btn_down && !scrolling && !hold_sent && !gesture_done) begin
          if (press_clicks == CLICKS_SINGLE && held >= cfg_right_hold) begin
            r.tap        = TAP_RIGHT;
            hold_sent    = 1'b1;
            click_tally  = CLICKS_NONE;
            press_clicks = CLICKS_NONE;
          end else if (press_clicks == CLICKS_DOUBLE && held >= cfg_middle_hold) begin
            r.tap        = TAP_MIDDLE;
            hold_sent    = 1'b1;
            click_tally  = CLICKS_NONE;
            press_clicks = CLICKS_NONE;
          end
        end
      end
      OP_PRESS: begin
        btn_down     = 1'b1;
        hold_sent    = 1'b0;
        gesture_done = 1'b0;
        dragging     = 1'b0;
        if (gap < cfg_double_click && click_tally == CLICKS_SINGLE) begin
          click_tally = CLICKS_DOUBLE;
        end else begin
          click_tally = CLICKS_SINGLE;
        end
        press_clicks = click_tally;
        press_t      = now;
      end
      OP_RELEASE: begin
        btn_down  = 1'b0;
        release_t = now;
        if (scrolling) begin
          scrolling    = 1'b0;
          click_tally  = CLICKS_NONE;
          press_clicks = CLICKS_NONE;
          acc_h        = 0;
          acc_v        = 0;
        end else if (dragging) begin
          dragging     = 1'b0;
          click_tally  = CLICKS_NONE;
          press_clicks = CLICKS_NONE;
        end else if (hold_sent) begin
          press_clicks = CLICKS_NONE;
        end else if (press_clicks == CLICKS_DOUBLE) begin
          if (!gesture_done) r.tap = TAP_LEFT;
          click_tally  = CLICKS_NONE;
          press_clicks = CLICKS_NONE;
        end else begin
          r.tap = TAP_LEFT;
        end
      end
      default: begin
        if (btn_down && !scrolling && !gesture_done) begin
          // -128 counts as magnitude 128
          ax        = (dx < 0) ? -int'(dx) : int'(dx);
          ay        = (dy < 0) ? -int'(dy) : int'(dy);
          mv_drag   = (ax >= int'(cfg_drag_min)) || (ay >= int'(cfg_drag_min));
          mv_scroll = (ax >= int'(cfg_scroll_min)) || (ay >= int'(cfg_scroll_min));
          if (press_clicks == CLICKS_DOUBLE) begin
            if (held >= cfg_scroll_arm && mv_scroll) begin
              scrolling    = 1'b1;
              gesture_done = 1'b1;
              click_tally  = CLICKS_NONE;
              press_clicks = CLICKS_NONE;
              acc_h        = 0;
              acc_v        = 0;
            end
          end else if (press_clicks == CLICKS_SINGLE && !hold_sent) begin
            if (held >= cfg_drag_arm && mv_drag) begin
              dragging     = 1'b1;
              gesture_done = 1'b1;
            end
          end
        end
        r.buttons = dragging ? (btn | 8'h01) : (btn & 8'hFE);
        if (scrolling) begin
          div   = (cfg_divisor < MIN_DIVISOR) ? int'(MIN_DIVISOR) : int'(cfg_divisor);
          acc_h = acc_h + dx;
          acc_v = acc_v - dy;  // vertical axis inverted
          qh    = acc_h / div;
          qv    = acc_v / div;
          acc_h = acc_h - qh * div;
          acc_v = acc_v - qv * div;
          r.h   = qh[7:0];
          r.v   = qv[7:0];
        end else begin
          r.x = dx;
          r.y = dy;
          r.h = wh;
          r.v = wv;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    report_t want, got;
    logic    bad;
    if (rst) begin
      cfg_right_hold   = 16'd400;
      cfg_middle_hold  = 16'd250;
      cfg_scroll_arm   = 16'd120;
      cfg_double_click = 16'd250;
      cfg_drag_arm     = 16'd70;
      cfg_drag_min     = 8'd2;
      cfg_scroll_min   = 8'd3;
      cfg_divisor      = 7'd17;
      btn_down         = 1'b0;
      hold_sent        = 1'b0;
      gesture_done     = 1'b0;
      dragging         = 1'b0;
      scrolling        = 1'b0;
      click_tally      = CLICKS_NONE;
      press_clicks     = CLICKS_NONE;
      press_t          = '0;
      release_t        = '0;
      acc_h            = 0;
      acc_v            = 0;
      report_q.delete();
      results_seen     <= 0;
      open_count       <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_RIGHT_HOLD:   cfg_right_hold   = wr_data;
          REG_MIDDLE_HOLD:  cfg_middle_hold  = wr_data;
          REG_SCROLL_ARM:   cfg_scroll_arm   = wr_data;
          REG_DOUBLE_CLICK: cfg_double_click = wr_data;
          REG_DRAG_ARM:     cfg_drag_arm     = wr_data;
          REG_DRAG_MIN:     cfg_drag_min     = wr_data[7:0];
          REG_SCROLL_MIN:   cfg_scroll_min   = wr_data[7:0];
          default:          cfg_divisor      = wr_data[6:0];
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = report_t'(m_tdata[41:0]);
        if (report_q.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= 10)
            $display("%0t: unexpected word tap=%0d x=%0d y=%0d h=%0d v=%0d btn=%02h",
                     $time, got.tap, got.x, got.y, got.h, got.v, got.buttons);
        end else begin
          want = report_q.pop_front();
          bad  = (want.tap !== got.tap) || (want.x !== got.x) || (want.y !== got.y) ||
                 (want.h !== got.h) || (want.v !== got.v) ||
                 (want.buttons !== got.buttons);
          if (bad) begin
            mismatch_n++;
            if (mismatch_n <= 10) begin
              $display("%0t: word %0d expected tap=%0d x=%0d y=%0d h=%0d v=%0d btn=%02h",
                       $time, results_seen, want.tap, want.x, want.y, want.h, want.v,
                       want.buttons);
              $display("%0t: word %0d actual   tap=%0d x=%0d y=%0d h=%0d v=%0d btn=%02h",
                       $time, results_seen, got.tap, got.x, got.y, got.h, got.v,
                       got.buttons);
            end
          end
        end
        results_seen <= results_seen + 1;
      end
      if (s_tvalid && s_tready) begin
        predict_report(s_tuser, s_tdata, want);
        report_q.push_back(want);
      end
      open_count <= report_q.size();
    end
    fail_count <= mismatch_n;
  end

endmodule

/* sim/smart_button_gesture_scroll_tb.sv */
`timescale 1ns / 100ps

module smart_button_gesture_scroll_tb;
  import sbgs_pkg::*;

  typedef enum {G_CLICK, G_DOUBLE, G_RIGHT, G_MIDDLE, G_DRAG, G_SCROLL, G_NOISE} gesture_t;

  localparam int WORD_TARGET = 925;  // directed words plus about 900 random
  localparam int PHASE_WORDS = 130;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data  = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [1:0]            s_tuser  = '0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int results_seen, open_count, fail_count;

  logic        steady      = 1'b0;  // no idling on either side while set
  int          stall_left  = 0;
  logic [15:0] stamp       = '0;
  int          words_sent  = 0;
  int          op_count[4] = '{0, 0, 0, 0};
  int          cfg_val[8];
  int          phase;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  smart_button_gesture_scroll dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sbgs_gesture_checker gesture_check (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tuser      (s_tuser),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .results_seen (results_seen),
    .open_count   (open_count),
    .fail_count   (fail_count)
  );

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] axis_val();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 8) - 4);
      1:       return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // a few ms either side of a threshold
  function automatic int near_ms(input int thr);
    int n;
    n = thr + int'($urandom_range(0, 6)) - 3;
    return (n < 0) ? 0 : n;
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_word(input sbgs_op_t op, input logic [7:0] dx, input logic [7:0] dy,
                           input logic [7:0] btn, input logic [7:0] wh,
                           input logic [7:0] wv);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {wv, wh, btn, dy, dx, stamp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    op_count[op]++;
  endtask

  task automatic send_op(input sbgs_op_t op);
    send_word(op, axis_val(), axis_val(), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // stop sending and wait for every outstanding word to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(input int p);
    case (p)
      0: begin
        cfg_val[REG_RIGHT_HOLD]   = 0;
        cfg_val[REG_MIDDLE_HOLD]  = 0;
        cfg_val[REG_SCROLL_ARM]   = 0;
        cfg_val[REG_DOUBLE_CLICK] = 0;
        cfg_val[REG_DRAG_ARM]     = 0;
        cfg_val[REG_DRAG_MIN]     = 0;
        cfg_val[REG_SCROLL_MIN]   = 0;
        cfg_val[REG_SCROLL_DIV]   = 0;
      end
      1: begin
        cfg_val[REG_RIGHT_HOLD]   = 65535;
        cfg_val[REG_MIDDLE_HOLD]  = 65535;
        cfg_val[REG_SCROLL_ARM]   = 65535;
        cfg_val[REG_DOUBLE_CLICK] = 65535;
        cfg_val[REG_DRAG_ARM]     = 65535;
        cfg_val[REG_DRAG_MIN]     = 128;
        cfg_val[REG_SCROLL_MIN]   = 128;
        cfg_val[REG_SCROLL_DIV]   = 127;
      end
      2: begin
        cfg_val[REG_RIGHT_HOLD]   = 400;
        cfg_val[REG_MIDDLE_HOLD]  = 250;
        cfg_val[REG_SCROLL_ARM]   = 120;
        cfg_val[REG_DOUBLE_CLICK] = 250;
        cfg_val[REG_DRAG_ARM]     = 70;
        cfg_val[REG_DRAG_MIN]     = 2;
        cfg_val[REG_SCROLL_MIN]   = 3;
        cfg_val[REG_SCROLL_DIV]   = 1;
      end
      default: begin
        cfg_val[REG_RIGHT_HOLD]   = $urandom_range(0, 600);
        cfg_val[REG_MIDDLE_HOLD]  = $urandom_range(0, 600);
        cfg_val[REG_SCROLL_ARM]   = $urandom_range(0, 300);
        cfg_val[REG_DOUBLE_CLICK] = $urandom_range(0, 400);
        cfg_val[REG_DRAG_ARM]     = $urandom_range(0, 200);
        cfg_val[REG_DRAG_MIN]     = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(0, 8);
        cfg_val[REG_SCROLL_MIN]   = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(0, 8);
        cfg_val[REG_SCROLL_DIV]   = $urandom_range(0, 1) ? $urandom_range(2, 20)
                                                         : $urandom_range(2, 127);
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_IDX_W'(i);
      wr_data  <= CFG_DATA_W'(cfg_val[i]);
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic run_gesture(input gesture_t kind);
    int          n, hold;
    logic [15:0] t0;
    case (kind)
      G_CLICK: begin
        send_op(OP_PRESS);
        stamp += 16'($urandom_range(0, 80));
        if ($urandom_range(0, 2) == 0) send_op(OP_MOTION);
        send_op(OP_RELEASE);
      end
      G_DOUBLE: begin
        send_op(OP_PRESS);
        stamp += 16'($urandom_range(0, 60));
        send_op(OP_RELEASE);
        stamp += 16'(near_ms(cfg_val[REG_DOUBLE_CLICK]));
        send_op(OP_PRESS);
        stamp += 16'($urandom_range(0, 60));
        send_op(OP_RELEASE);
      end
      G_RIGHT, G_MIDDLE: begin
        if (kind == G_MIDDLE) begin
          send_op(OP_PRESS);
          stamp += 16'($urandom_range(0, 40));
          send_op(OP_RELEASE);
          stamp += 16'($urandom_range(0, 40));
        end
        send_op(OP_PRESS);
        t0   = stamp;
        hold = (kind == G_RIGHT) ? cfg_val[REG_RIGHT_HOLD] : cfg_val[REG_MIDDLE_HOLD];
        n    = $urandom_range(1, 4);
        repeat (n) begin
          stamp = t0 + 16'(near_ms(hold));
          if ($urandom_range(0, 5) == 0) send_op(OP_MOTION);
          else send_op(OP_TICK);
        end
        stamp += 16'($urandom_range(0, 30));
        send_op(OP_RELEASE);
      end
      G_DRAG: begin
        send_op(OP_PRESS);
        stamp += 16'(near_ms(cfg_val[REG_DRAG_ARM]));
        n = $urandom_range(2, 8);
        repeat (n) begin
          send_op(OP_MOTION);
          stamp += 16'($urandom_range(1, 12));
        end
        send_op(OP_RELEASE);
      end
      G_SCROLL: begin
        send_op(OP_PRESS);
        stamp += 16'($urandom_range(0, 40));
        send_op(OP_RELEASE);
        stamp += 16'($urandom_range(0, 40));
        send_op(OP_PRESS);
        stamp += 16'(near_ms(cfg_val[REG_SCROLL_ARM]));
        n = $urandom_range(3, 16);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_op(OP_TICK);
          else send_op(OP_MOTION);
          stamp += 16'($urandom_range(1, 12));
        end
        send_op(OP_RELEASE);
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          stamp += ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
          send_op(sbgs_op_t'($urandom_range(0, 3)));
        end
      end
    endcase
  endtask

  initial begin
    int       phase_end, pick;
    gesture_t kind;
    cfg_val[REG_RIGHT_HOLD]   = 400;
    cfg_val[REG_MIDDLE_HOLD]  = 250;
    cfg_val[REG_SCROLL_ARM]   = 120;
    cfg_val[REG_DOUBLE_CLICK] = 250;
    cfg_val[REG_DRAG_ARM]     = 70;
    cfg_val[REG_DRAG_MIN]     = 2;
    cfg_val[REG_SCROLL_MIN]   = 3;
    cfg_val[REG_SCROLL_DIV]   = 17;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed pass at reset defaults
    stamp = 16'd0;     send_op(OP_TICK);
    stamp = 16'd5;     send_op(OP_RELEASE);  // release with no press: left tap
    stamp = 16'hFFFF;  send_word(OP_MOTION, 8'h7F, 8'h80, 8'hFF, 8'h80, 8'h7F);
    stamp = 16'd1000;  send_op(OP_PRESS);
    stamp = 16'd1010;  send_op(OP_PRESS);    // press while already down
    stamp = 16'd1100;  send_word(OP_MOTION, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
    stamp = 16'd1105;  send_word(OP_MOTION, 8'h03, 8'hFD, 8'hFE, 8'h01, 8'hFF);
    stamp = 16'd1200;  send_op(OP_RELEASE);
    stamp = 16'd1300;  send_op(OP_PRESS);
    stamp = 16'd1350;  send_op(OP_RELEASE);
    stamp = 16'd1400;  send_op(OP_PRESS);
    stamp = 16'd1530;  send_word(OP_MOTION, 8'h80, 8'h7F, 8'h00, 8'h7F, 8'h80);
    stamp = 16'd1540;  send_word(OP_MOTION, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h00);
    stamp = 16'd1560;  send_op(OP_TICK);
    stamp = 16'd1600;  send_op(OP_RELEASE);
    stamp = 16'd2000;  send_op(OP_PRESS);
    stamp = 16'd2399;  send_op(OP_TICK);
    stamp = 16'd2400;  send_op(OP_TICK);     // right tap
    stamp = 16'd2450;  send_op(OP_RELEASE);
    stamp = 16'd3000;  send_op(OP_PRESS);
    stamp = 16'd3010;  send_op(OP_RELEASE);
    stamp = 16'd3020;  send_op(OP_PRESS);
    stamp = 16'd3269;  send_op(OP_TICK);
    stamp = 16'd3270;  send_op(OP_TICK);     // middle tap
    stamp = 16'd3300;  send_op(OP_RELEASE);

    for (phase = 0; words_sent < WORD_TARGET; phase++) begin
      drain();
      load_setting(phase);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        steady <= ($urandom_range(0, 4) == 0);
        stamp += ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        pick = $urandom_range(0, 99);
        if (pick < 12)      kind = G_CLICK;
        else if (pick < 22) kind = G_DOUBLE;
        else if (pick < 34) kind = G_RIGHT;
        else if (pick < 46) kind = G_MIDDLE;
        else if (pick < 64) kind = G_DRAG;
        else if (pick < 86) kind = G_SCROLL;
        else                kind = G_NOISE;
        run_gesture(kind);
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d words: %0d ticks, %0d presses, %0d releases, %0d motion reports",
             words_sent, op_count[OP_TICK], op_count[OP_PRESS], op_count[OP_RELEASE],
             op_count[OP_MOTION]);
    $display("across %0d register settings after the reset defaults, stalls on both sides",
             phase);
    if (fail_count == 0 && open_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
